// ----- rtl/core/c2d_pkg.sv -----
// Shared constants, request codes and helpers for the 2D convolution unit.
package c2d_pkg;

  localparam int MAX_IN_CHANNELS  = 8;
  localparam int MAX_OUT_CHANNELS = 8;
  localparam int MAX_KERNEL       = 8;
  localparam int MAX_ROWS         = 32;
  localparam int MAX_COLS         = 32;

  localparam int CH_W   = $clog2(MAX_IN_CHANNELS);
  localparam int OC_W   = $clog2(MAX_OUT_CHANNELS);
  localparam int TAP_W  = $clog2(MAX_KERNEL);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLS);

  localparam int WEIGHT_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
  localparam int IMAGE_DEPTH  = MAX_IN_CHANNELS * MAX_ROWS * MAX_COLS;
  localparam int WADDR_W      = $clog2(WEIGHT_DEPTH);
  localparam int IADDR_W      = $clog2(IMAGE_DEPTH);

  localparam int ACC_W = 48;

  // request operation codes
  localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
  localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
  localparam logic [1:0] OP_LOAD_PIXEL  = 2'd2;
  localparam logic [1:0] OP_COMPUTE     = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_PAD      = 3'd0;
  localparam logic [2:0] CFG_STEP     = 3'd1;
  localparam logic [2:0] CFG_TAPS     = 3'd2;
  localparam logic [2:0] CFG_CHANNELS = 3'd3;
  localparam logic [2:0] CFG_ROWS     = 3'd4;
  localparam logic [2:0] CFG_COLS     = 3'd5;

  // clamp a size register into [1, hi]
  function automatic logic [5:0] clamp_len(input logic [5:0] v, input logic [5:0] hi);
    logic [5:0] r;
    if (v == 6'd0) begin
      r = 6'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/conv2d_padded_strided_unit.sv -----
// Multichannel 2D convolution unit with zero padding and stride, one shared MAC.
// Loads retire at acceptance; a compute request walks N = channels * taps * taps (up to 512)
// taps on the single MAC, then passes through drain and finish into the result register.
// Out-of-range positions skip the walk and go straight to the finish state.
// One request in flight: in_ready is low from a compute's acceptance until its result is loaded.
// Reset (rst_n, synchronous, active low) restores config defaults; the stores are not cleared.
module conv2d_padded_strided_unit
  import c2d_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [2:0]         in_out_chan,
  input  logic [2:0]         in_in_chan,
  input  logic [2:0]         in_tap_row,
  input  logic [2:0]         in_tap_col,
  input  logic [4:0]         in_pos_row,
  input  logic [4:0]         in_pos_col,
  input  logic signed [15:0] in_sample,
  input  logic signed [31:0] in_bias_word,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] out_conv_sum,
  output logic               out_status
);

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [2:0] pad_r;
  logic [3:0] step_r;
  logic [3:0] taps_r;
  logic [3:0] chans_r;
  logic [5:0] rows_r;
  logic [5:0] cols_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_r   <= 3'd0;
      step_r  <= 4'd1;
      taps_r  <= 4'd3;
      chans_r <= 4'd1;
      rows_r  <= 6'd32;
      cols_r  <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAD:      pad_r   <= cfg_data[2:0];
        CFG_STEP:     step_r  <= cfg_data[3:0];
        CFG_TAPS:     taps_r  <= cfg_data[3:0];
        CFG_CHANNELS: chans_r <= cfg_data[3:0];
        CFG_ROWS:     rows_r  <= cfg_data;
        CFG_COLS:     cols_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes after clamping; stride zero behaves as one.
  logic [3:0] stride_eff;
  logic [3:0] k_eff;
  logic [3:0] chans_eff;
  logic [5:0] rows_eff;
  logic [5:0] cols_eff;
  logic [2:0] k_last;
  logic [2:0] ch_last;

  assign stride_eff = (step_r == 4'd0) ? 4'd1 : step_r;
  assign k_eff      = 4'(clamp_len({2'b00, taps_r}, 6'(MAX_KERNEL)));
  assign chans_eff  = 4'(clamp_len({2'b00, chans_r}, 6'(MAX_IN_CHANNELS)));
  assign rows_eff   = clamp_len(rows_r, 6'(MAX_ROWS));
  assign cols_eff   = clamp_len(cols_r, 6'(MAX_COLS));
  assign k_last     = 3'(k_eff - 4'd1);
  assign ch_last    = 3'(chans_eff - 4'd1);

  // ---------------------------------------------------------------------------
  // Request acceptance and the window origin.
  // A position is in range when pos*stride + k <= size + 2*pad, which is the
  // same test as pos < (size - k + 2*pad)/stride + 1 without a divider.
  // ---------------------------------------------------------------------------
  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       in_acc;
  logic       is_compute;
  logic [8:0] prow_scaled;
  logic [8:0] pcol_scaled;
  logic       row_fits;
  logic       col_fits;

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign is_compute = (in_operation == OP_COMPUTE);

  assign prow_scaled = 9'(in_pos_row) * 9'(stride_eff);
  assign pcol_scaled = 9'(in_pos_col) * 9'(stride_eff);
  assign row_fits = (10'(prow_scaled) + 10'(k_eff)) <= (10'(rows_eff) + 10'({pad_r, 1'b0}));
  assign col_fits = (10'(pcol_scaled) + 10'(k_eff)) <= (10'(cols_eff) + 10'({pad_r, 1'b0}));

  // ---------------------------------------------------------------------------
  // Stores. Weight and image are single-port-write, registered-read memories.
  // ---------------------------------------------------------------------------
  logic signed [15:0] weight_mem [WEIGHT_DEPTH];
  logic signed [15:0] image_mem  [IMAGE_DEPTH];
  logic signed [31:0] bias_mem   [MAX_OUT_CHANNELS];

  logic [WADDR_W-1:0] w_waddr;
  logic [IADDR_W-1:0] i_waddr;
  logic [WADDR_W-1:0] w_raddr;
  logic [IADDR_W-1:0] i_raddr;
  logic signed [15:0] w_rd_r;
  logic signed [15:0] i_rd_r;

  assign w_waddr = {in_out_chan, in_in_chan, in_tap_row, in_tap_col};
  assign i_waddr = {in_in_chan, in_pos_row, in_pos_col};

  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_LOAD_WEIGHT) begin
      weight_mem[w_waddr] <= in_sample;
    end
    w_rd_r <= weight_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_LOAD_PIXEL) begin
      image_mem[i_waddr] <= in_sample;
    end
    i_rd_r <= image_mem[i_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_operation == OP_LOAD_BIAS) begin
      bias_mem[in_out_chan] <= in_bias_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Tap walker: channel, kernel row, kernel column; one tap per cycle.
  // ---------------------------------------------------------------------------
  logic [OC_W-1:0]   oc_r;
  logic [CH_W-1:0]   c_r;
  logic [TAP_W-1:0]  kr_r;
  logic [TAP_W-1:0]  kc_r;
  logic signed [9:0] row_base_r;
  logic signed [9:0] col_base_r;
  logic signed [9:0] ir;
  logic signed [9:0] icol;
  logic              tap_ok;
  logic              last_tap;

  assign ir     = row_base_r + $signed(10'(kr_r));
  assign icol   = col_base_r + $signed(10'(kc_r));
  assign tap_ok = !ir[9] && (ir < $signed(10'(rows_eff)))
               && !icol[9] && (icol < $signed(10'(cols_eff)));
  assign last_tap = (kc_r == k_last) && (kr_r == k_last) && (c_r == ch_last);

  assign w_raddr = {oc_r, c_r, kr_r, kc_r};
  assign i_raddr = {c_r, ir[ROW_W-1:0], icol[COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (in_acc && is_compute) begin
      oc_r       <= in_out_chan;
      c_r        <= '0;
      kr_r       <= '0;
      kc_r       <= '0;
      row_base_r <= $signed(10'(prow_scaled)) - $signed(10'(pad_r));
      col_base_r <= $signed(10'(pcol_scaled)) - $signed(10'(pad_r));
    end else if (state_r == ST_RUN) begin
      if (kc_r == k_last) begin
        kc_r <= '0;
        if (kr_r == k_last) begin
          kr_r <= '0;
          c_r  <= c_r + 1'b1;
        end else begin
          kr_r <= kr_r + 1'b1;
        end
      end else begin
        kc_r <= kc_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // MAC pipeline: read -> multiply -> accumulate. Padding taps multiply as zero.
  // ---------------------------------------------------------------------------
  logic               rd_v_r;
  logic               rd_ok_r;
  logic               prod_v_r;
  logic signed [31:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic               stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= (state_r == ST_RUN);
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= tap_ok;
    prod_r  <= rd_ok_r ? (w_rd_r * i_rd_r) : 32'sd0;
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_compute) begin
      if (row_fits && col_fits) begin
        acc_r  <= {{(ACC_W-32){bias_mem[in_out_chan][31]}}, bias_mem[in_out_chan]};
        stat_r <= 1'b0;
      end else begin
        acc_r  <= '0;
        stat_r <= 1'b1;
      end
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W-32){prod_r[31]}}, prod_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_load;

  assign out_load = (state_r == ST_FINISH) && (!out_valid || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && is_compute) begin
          state_nxt = (row_fits && col_fits) ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !prod_v_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  logic signed [47:0] out_sum_r;
  logic               out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sum_r    <= acc_r;
      out_status_r <= stat_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_conv_sum = out_sum_r;
  assign out_status   = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_read_only_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r) == ST_RUN)
    else $error("tap read issued outside the run state");

  a_finish_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == ST_IDLE)
    else $error("finished request did not reach the result register");

  a_status_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r |-> out_sum_r == 48'sd0)
    else $error("out-of-range result carries a nonzero sum");

endmodule
